// ----- rtl/core/mm_pkg.sv -----
// shared types and constants of the matrix multiply block
package mm_pkg;

  localparam int COORD_W = 3;
  localparam int DIM_W   = 4;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 36;

  typedef enum logic [1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [1:0] REG_ROWS_A     = 2'd0;
  localparam logic [1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [1:0] REG_COLS_B     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] inner_size;
    logic [DIM_W-1:0] cols_b;
  } dims_t;

  typedef struct packed {
    logic valid;
    logic first;
  } mac_issue_t;

  typedef struct packed {
    logic             busy;
    logic [SUM_W-1:0] acc;
  } mac_stat_t;

endpackage

// ----- rtl/core/mm_ram.sv -----
// generic simple dual port ram with registered read
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/mm_store.sv -----
// element store: ram plus per-entry written flags, unwritten entries read as zero
module mm_store #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic signed [WIDTH-1:0]  rdata
);

  logic [DEPTH-1:0] written;
  logic             rvalid;
  logic [WIDTH-1:0] q;

  mm_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      rvalid <= written[raddr];
    end
  end

  assign rdata = rvalid ? q : '0;

endmodule

// ----- rtl/core/mm_mac.sv -----
// shared multiply-accumulate unit: product register, then 36-bit wrapping accumulator
module mm_mac #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mm_pkg::mac_issue_t           issue,
  input  logic signed [ELEM_WIDTH-1:0] a_data,
  input  logic signed [ELEM_WIDTH-1:0] b_data,
  output mm_pkg::mac_stat_t            stat
);
  import mm_pkg::*;

  localparam int PROD_W = 2 * ELEM_WIDTH;

  logic                     v1, f1, v2, f2;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  prod_ext;
  logic [SUM_W-1:0]         acc;

  generate
    if (PROD_W >= SUM_W) begin : g_trunc
      assign prod_ext = prod[SUM_W-1:0];
    end else begin : g_ext
      assign prod_ext = SUM_W'(prod);
    end
  endgenerate

  // stage 1 lines up with the registered store read, stage 2 holds the product
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue.valid;
      v2 <= v1;
    end
    f1   <= issue.first;
    f2   <= f1;
    prod <= PROD_W'(a_data) * PROD_W'(b_data);
    if (v2) begin
      acc <= f2 ? prod_ext : acc + prod_ext;
    end
  end

  assign stat.busy = v1 | v2;
  assign stat.acc  = acc;

endmodule

// ----- rtl/core/mm_seq.sv -----
// sequencer: load handling, product loop counters and output register
module mm_seq #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16,
  parameter int ADDR_W     = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mm_pkg::dims_t                dims,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_kind,
  input  logic [mm_pkg::COORD_W-1:0]   in_row,
  input  logic [mm_pkg::COORD_W-1:0]   in_col,
  input  logic signed [mm_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mm_pkg::COORD_W-1:0]   out_row,
  output logic [mm_pkg::COORD_W-1:0]   out_col,
  output logic [mm_pkg::SUM_W-1:0]     out_sum,
  output logic                         out_status,
  output logic                         out_last,
  output logic                         we_a,
  output logic                         we_b,
  output logic [ADDR_W-1:0]            waddr,
  output logic [ELEM_WIDTH-1:0]        wdata,
  output logic [ADDR_W-1:0]            raddr_a,
  output logic [ADDR_W-1:0]            raddr_b,
  output mm_pkg::mac_issue_t           issue,
  input  mm_pkg::mac_stat_t            mac_stat
);
  import mm_pkg::*;

  state_t               state, state_next;
  logic [COORD_W-1:0]   m_idx, m_next, n_idx, n_next, i_idx, i_next;
  logic                 out_valid_next, out_status_next, out_last_next;
  logic [COORD_W-1:0]   out_row_next, out_col_next;
  logic [SUM_W-1:0]     out_sum_next;
  logic                 accept, is_a, load_ok, elem_last, row_end, inner_end;
  logic [DIM_W-1:0]     lim_r, lim_c;

  assign is_a    = (in_kind == KIND_LOAD_A);
  assign lim_r   = is_a ? dims.rows_a : dims.inner_size;
  assign lim_c   = is_a ? dims.inner_size : dims.cols_b;
  assign load_ok = ({1'b0, in_row} < lim_r) && ({1'b0, in_col} < lim_c);

  assign waddr   = ADDR_W'(in_row * MAX_DIM + in_col);
  assign wdata   = ELEM_WIDTH'(in_value);
  assign raddr_a = ADDR_W'(m_idx * MAX_DIM + i_idx);
  assign raddr_b = ADDR_W'(i_idx * MAX_DIM + n_idx);

  assign row_end   = ({1'b0, n_idx} == dims.cols_b - DIM_W'(1));
  assign elem_last = row_end && ({1'b0, m_idx} == dims.rows_a - DIM_W'(1));
  assign inner_end = ({1'b0, i_idx} == dims.inner_size - DIM_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      m_idx     <= '0;
      n_idx     <= '0;
      i_idx     <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      m_idx     <= m_next;
      n_idx     <= n_next;
      i_idx     <= i_next;
    end
    out_row    <= out_row_next;
    out_col    <= out_col_next;
    out_sum    <= out_sum_next;
    out_status <= out_status_next;
    out_last   <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    m_next          = m_idx;
    n_next          = n_idx;
    i_next          = i_idx;
    out_valid_next  = out_valid & ~out_ready;
    out_row_next    = out_row;
    out_col_next    = out_col;
    out_sum_next    = out_sum;
    out_status_next = out_status;
    out_last_next   = out_last;
    we_a            = 1'b0;
    we_b            = 1'b0;
    issue           = '0;
    in_ready        = (state == ST_IDLE) && (!out_valid || out_ready);
    accept          = in_valid && in_ready;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind) inside
            KIND_LOAD_A, KIND_LOAD_B: begin
              we_a            = is_a && load_ok;
              we_b            = !is_a && load_ok;
              out_valid_next  = 1'b1;
              out_row_next    = in_row;
              out_col_next    = in_col;
              out_sum_next    = '0;
              out_status_next = load_ok ? STATUS_OK : STATUS_RANGE;
              out_last_next   = 1'b1;
            end
            KIND_COMPUTE: begin
              if (dims.rows_a != '0 && dims.cols_b != '0) begin
                m_next     = '0;
                n_next     = '0;
                i_next     = '0;
                state_next = (dims.inner_size == '0) ? ST_DRAIN : ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        issue.valid = 1'b1;
        issue.first = (i_idx == '0);
        if (inner_end) begin
          i_next     = '0;
          state_next = ST_DRAIN;
        end else begin
          i_next = i_idx + COORD_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!mac_stat.busy && (!out_valid || out_ready)) begin
          out_valid_next  = 1'b1;
          out_row_next    = m_idx;
          out_col_next    = n_idx;
          out_sum_next    = (dims.inner_size == '0) ? '0 : mac_stat.acc;
          out_status_next = STATUS_OK;
          out_last_next   = elem_last;
          if (elem_last) begin
            state_next = ST_IDLE;
          end else begin
            if (row_end) begin
              n_next = '0;
              m_next = m_idx + COORD_W'(1);
            end else begin
              n_next = n_idx + COORD_W'(1);
            end
            state_next = (dims.inner_size == '0) ? ST_DRAIN : ST_RUN;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/matrix_multiply_top.sv -----
// top level of the integer matrix multiply block
// Integer matrix multiply: elements of A (rows_a x inner_size) and B
// (inner_size x cols_b) are loaded one item at a time on the input stream and
// each load is answered by one item carrying its row, column and a status
// (0 ok, 1 index outside the configured shape; a refused load leaves the
// store unchanged). A compute item then streams out every product element in
// row-major order as a 36-bit signed wrapping sum, with tlast on the final
// one. Loads are taken one per cycle as long as the output side keeps up.
// A compute item holds the input off while it runs, and output stalls
// lengthen it. Its pace comes from the single shared multiplier and the
// one read port of each element store, walked by the sequencer one
// multiply-accumulate per cycle, then a two-stage drain before each result.
// Both stores read as zero after reset; per-entry written flags make that
// immediate, so no clearing pass is needed. Dimension registers above
// min(MAX_DIM, 8) act as that bound; a zero product dimension makes a compute
// item return nothing, and kind 3 is ignored.
module matrix_multiply_top #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // row [2:0], col [5:3], value [21:6], zero pad
  input  logic [1:0]  s_tuser,   // kind [1:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_row [2:0], out_col [5:3], sum [41:6], zero pad
  output logic        m_tuser,   // status [0]
  output logic        m_tlast    // last result of the item
);
  import mm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'((MAX_DIM < 8) ? MAX_DIM : 8);

  // raw register values as written
  logic [DIM_W-1:0] rows_a, inner_size, cols_b;
  logic             cfg_we;
  dims_t            dims;

  logic                         we_a, we_b;
  logic [ADDR_W-1:0]            waddr, raddr_a, raddr_b;
  logic [ELEM_WIDTH-1:0]        wdata;
  logic signed [ELEM_WIDTH-1:0] a_data, b_data;
  mac_issue_t                   issue;
  mac_stat_t                    mac_stat;

  logic [COORD_W-1:0] out_row, out_col;
  logic [SUM_W-1:0]   out_sum;
  logic               out_status;

  // register writes complete in the access phase, no wait states
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= DIM_W'(2);
      inner_size <= DIM_W'(2);
      cols_b     <= DIM_W'(2);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_ROWS_A:     rows_a     <= pwdata[DIM_W-1:0];
        REG_INNER_SIZE: inner_size <= pwdata[DIM_W-1:0];
        REG_COLS_B:     cols_b     <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS_A:     prdata = {28'b0, rows_a};
      REG_INNER_SIZE: prdata = {28'b0, inner_size};
      REG_COLS_B:     prdata = {28'b0, cols_b};
      default:        prdata = '0;
    endcase
  end

  // dimensions saturate at the largest shape the index fields can address
  assign dims.rows_a     = (rows_a > DIM_CAP) ? DIM_CAP : rows_a;
  assign dims.inner_size = (inner_size > DIM_CAP) ? DIM_CAP : inner_size;
  assign dims.cols_b     = (cols_b > DIM_CAP) ? DIM_CAP : cols_b;

  mm_seq #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .dims       (dims),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (s_tuser),
    .in_row     (s_tdata[2:0]),
    .in_col     (s_tdata[5:3]),
    .in_value   (s_tdata[21:6]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_sum    (out_sum),
    .out_status (out_status),
    .out_last   (m_tlast),
    .we_a       (we_a),
    .we_b       (we_b),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .issue      (issue),
    .mac_stat   (mac_stat)
  );

  // element stores, addressed row * MAX_DIM + col
  mm_store #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .rst   (rst),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (a_data)
  );

  mm_store #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .rst   (rst),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (b_data)
  );

  // one multiplier shared by every product element
  mm_mac #(.ELEM_WIDTH(ELEM_WIDTH)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .a_data (a_data),
    .b_data (b_data),
    .stat   (mac_stat)
  );

  assign m_tdata = {6'b0, out_sum, out_col, out_row};
  assign m_tuser = out_status;

endmodule

// ----- rtl/core/mm_checker.sv -----
// port-level assertions for the matrix multiply top, bound to it
module mm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  import mm_pkg::*;

  // a load is answered in the next cycle, echoing its coordinates with a zero sum
  a_load_echo: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_LOAD_A || s_tuser == KIND_LOAD_B)
    |=> m_tvalid && m_tlast && m_tdata[5:0] == $past(s_tdata[5:0])
        && m_tdata[41:6] == '0)
    else $error("load item not answered with its echo");

  // a refused load is a single final item with zero sum
  a_refused_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_RANGE |-> m_tlast && m_tdata[41:6] == '0)
    else $error("refused load result malformed");

  // no new item while a result is stuck in the output register
  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output is stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready
    |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind matrix_multiply_top mm_checker u_mm_checker (.*);

// ----- tb/tb_top.sv -----
// self-checking testbench of the integer matrix multiply block
module tb_top;
  import mm_pkg::*;

  localparam int STRIDE        = 8;     // store row pitch, the block's MAX_DIM
  localparam int DIM_CAP       = 8;     // dimension registers saturate here
  localparam int ITEM_TARGET   = 380;   // counted items (ignored kind excluded)
  localparam int SETTLE_CYCLES = 20;    // extra cycles once nothing is pending
  localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int MISMATCH_SHOW = 10;

  // the unused kind code, ignored by the block
  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 16'sh7fff;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 16'sh8000;

  // one row of the directed table; typed rows carry their status by hand
  typedef struct {
    logic [1:0]                  kind;
    logic [COORD_W-1:0]          row;
    logic [COORD_W-1:0]          col;
    logic signed [VALUE_W-1:0]   value;
    bit                          typed;
    logic                        status;
  } stim_t;

  // one result item as the block should send it
  typedef struct {
    logic [COORD_W-1:0]          row;
    logic [COORD_W-1:0]          col;
    logic signed [SUM_W-1:0]     sum;
    logic                        status;
    logic                        last;
  } elem_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // row [2:0], col [5:3], value [21:6], zero pad
  logic [1:0]  s_tuser;   // kind [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;   // out_row [2:0], out_col [5:3], sum [41:6], zero pad
  logic        m_tuser;   // status [0]
  logic        m_tlast;

  // side band of the item on the bus: typed status of a directed row
  bit          item_typed;
  logic        item_status;

  // shadow of the block: shape registers and both element stores
  logic [DIM_W-1:0]          rows_cfg;
  logic [DIM_W-1:0]          inner_cfg;
  logic [DIM_W-1:0]          cols_cfg;
  logic signed [VALUE_W-1:0] a_store [STRIDE*STRIDE];
  logic signed [VALUE_W-1:0] b_store [STRIDE*STRIDE];

  elem_t due_elems [$];   // results still owed by the block, oldest first
  int    errors;
  int    items_sent;
  int    quiet_cycles;
  int    burst_left;

  stim_t dir_tab [16];

  matrix_multiply_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic int eff_dim(logic [DIM_W-1:0] d);
    return (d > DIM_CAP) ? DIM_CAP : int'(d);
  endfunction

  function automatic void log_mismatch(string msg);
    errors++;
    if (errors <= MISMATCH_SHOW) $display("%s", msg);
  endfunction

  // shadow of one accepted item: updates the stores, queues its results
  function automatic void predict_matrix_op(logic [1:0] kind, logic [COORD_W-1:0] row,
                                            logic [COORD_W-1:0] col,
                                            logic signed [VALUE_W-1:0] value,
                                            bit typed, logic typed_status);
    int ra;
    int ki;
    int cb;
    int lim_r;
    int lim_c;
    logic signed [SUM_W-1:0] acc;
    logic signed [31:0]      prod;
    elem_t e;
    ra = eff_dim(rows_cfg);
    ki = eff_dim(inner_cfg);
    cb = eff_dim(cols_cfg);
    case (kind)
      KIND_LOAD_A, KIND_LOAD_B: begin
        lim_r = (kind == KIND_LOAD_A) ? ra : ki;
        lim_c = (kind == KIND_LOAD_A) ? ki : cb;
        e.row = row;
        e.col = col;
        e.sum = '0;
        e.last = 1'b1;
        // a refused load leaves the store alone but is still answered
        e.status = (int'(row) < lim_r && int'(col) < lim_c) ? STATUS_OK : STATUS_RANGE;
        if (e.status == STATUS_OK) begin
          if (kind == KIND_LOAD_A) a_store[int'(row) * STRIDE + int'(col)] = value;
          else b_store[int'(row) * STRIDE + int'(col)] = value;
        end
        if (typed) e.status = typed_status;
        due_elems.push_back(e);
      end
      KIND_COMPUTE: begin
        // row-major walk; a zero product dimension yields nothing
        for (int m = 0; m < ra; m++) begin
          for (int n = 0; n < cb; n++) begin
            acc = '0;
            for (int i = 0; i < ki; i++) begin
              prod = a_store[m * STRIDE + i] * b_store[i * STRIDE + n];
              acc = acc + prod;
            end
            e.row = 3'(m);
            e.col = 3'(n);
            e.sum = acc;
            e.status = STATUS_OK;
            e.last = (m == ra - 1) && (n == cb - 1);
            due_elems.push_back(e);
          end
        end
      end
      default: begin
        // unused kind, no result
      end
    endcase
  endfunction

  // monitor: input acceptance feeds the shadow, results are checked in order
  always @(posedge clk) begin : monitor
    elem_t e;
    if (!rst) begin
      if (s_tvalid && s_tready)
        predict_matrix_op(s_tuser, s_tdata[2:0], s_tdata[5:3], s_tdata[21:6],
                          item_typed, item_status);
      if (m_tvalid && m_tready) begin
        if (due_elems.size() == 0) begin
          log_mismatch($sformatf("unexpected result: row %0d col %0d sum %0d status %0d last %0d",
                                 m_tdata[2:0], m_tdata[5:3], $signed(m_tdata[41:6]),
                                 m_tuser, m_tlast));
        end else begin
          e = due_elems.pop_front();
          if (m_tdata[2:0] !== e.row || m_tdata[5:3] !== e.col ||
              m_tdata[41:6] !== e.sum || m_tuser !== e.status || m_tlast !== e.last)
            log_mismatch($sformatf({"result mismatch: expected row %0d col %0d sum %0d ",
                                    "status %0d last %0d, got row %0d col %0d sum %0d ",
                                    "status %0d last %0d"},
                                   e.row, e.col, e.sum, e.status, e.last,
                                   m_tdata[2:0], m_tdata[5:3], $signed(m_tdata[41:6]),
                                   m_tuser, m_tlast));
        end
      end
      // watchdog: any handshake on any port counts as progress
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver back-pressure: a pattern mode, picked at random and changed when its countdown runs out
  int       rx_mode;
  int       rx_mode_left;
  int       rx_run_left;
  always @(posedge clk) begin
    if (rst) begin
      m_tready     <= 1'b0;
      rx_mode      <= 0;
      rx_mode_left <= 0;
      rx_run_left  <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(50, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;                            // always ready
        1: m_tready <= 1'($urandom_range(0, 1));        // coin toss
        2: m_tready <= ($urandom_range(0, 7) != 0);     // rare single stalls
        default: begin
          // alternating runs of stall and ready
          if (rx_run_left == 0) begin
            m_tready    <= !m_tready;
            rx_run_left <= $urandom_range(1, 30);
          end else begin
            rx_run_left <= rx_run_left - 1;
          end
        end
      endcase
    end
  end

  // one item on the input stream; returns once it is accepted and any gap after it is over
  task automatic send_item(logic [1:0] kind, logic [COORD_W-1:0] row,
                           logic [COORD_W-1:0] col, logic signed [VALUE_W-1:0] value,
                           bit typed, logic status);
    s_tvalid    <= 1'b1;
    s_tuser     <= kind;
    s_tdata     <= {2'b00, value, col, row};
    item_typed  <= typed;
    item_status <= status;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind != KIND_IGNORED) items_sent++;
    // bursts of random length, each followed by a gap of random length
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // stop sending, wait for every owed result, then let the block go quiet
  task automatic settle();
    if (s_tvalid) s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register transfer: setup cycle, then access cycle
  task automatic cfg_access(logic [1:0] idx, bit wr, logic [DIM_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr) begin
      case (idx)
        REG_ROWS_A:     rows_cfg  = val;
        REG_INNER_SIZE: inner_cfg = val;
        REG_COLS_B:     cols_cfg  = val;
        default: ;
      endcase
    end else if (prdata !== {28'd0, val}) begin
      log_mismatch($sformatf("register %0d read: expected %0d, got %0d", idx, val, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write the shape and read it back
  task automatic set_shape(logic [DIM_W-1:0] ra, logic [DIM_W-1:0] ki, logic [DIM_W-1:0] cb);
    cfg_access(REG_ROWS_A, 1'b1, ra);
    cfg_access(REG_INNER_SIZE, 1'b1, ki);
    cfg_access(REG_COLS_B, 1'b1, cb);
    cfg_access(REG_ROWS_A, 1'b0, ra);
    cfg_access(REG_INNER_SIZE, 1'b0, ki);
    cfg_access(REG_COLS_B, 1'b0, cb);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value(bit extreme_bias);
    if ($urandom_range(0, 3) < (extreme_bias ? 3 : 1))
      return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    return 16'($urandom);
  endfunction

  // main sequence
  initial begin : stimulus
    int phase;
    int n_items;
    int sel;
    int lim_r;
    int lim_c;
    logic [1:0] k;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    logic [DIM_W-1:0] d0;
    logic [DIM_W-1:0] d1;
    logic [DIM_W-1:0] d2;

    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    item_typed  = 1'b0;
    item_status = STATUS_OK;
    rows_cfg    = 4'd2;
    inner_cfg   = 4'd2;
    cols_cfg    = 4'd2;
    foreach (a_store[i]) a_store[i] = '0;
    foreach (b_store[i]) b_store[i] = '0;
    errors       = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    burst_left   = 4;

    // directed rows at the reset shape of 2 x 2 x 2
    dir_tab[0]  = '{KIND_COMPUTE, 3'd0, 3'd0, 16'sd0,  1'b0, STATUS_OK};   // stores zero
    dir_tab[1]  = '{KIND_LOAD_A,  3'd0, 3'd0, VAL_MAX, 1'b1, STATUS_OK};
    dir_tab[2]  = '{KIND_LOAD_A,  3'd1, 3'd1, VAL_MIN, 1'b1, STATUS_OK};
    dir_tab[3]  = '{KIND_LOAD_A,  3'd0, 3'd1, -16'sd1, 1'b1, STATUS_OK};
    dir_tab[4]  = '{KIND_LOAD_A,  3'd1, 3'd0, 16'sd1,  1'b1, STATUS_OK};
    dir_tab[5]  = '{KIND_LOAD_A,  3'd2, 3'd0, 16'sd5,  1'b1, STATUS_RANGE}; // row off shape
    dir_tab[6]  = '{KIND_LOAD_A,  3'd0, 3'd2, 16'sd5,  1'b1, STATUS_RANGE}; // col off shape
    dir_tab[7]  = '{KIND_LOAD_A,  3'd7, 3'd7, VAL_MAX, 1'b1, STATUS_RANGE};
    dir_tab[8]  = '{KIND_LOAD_B,  3'd0, 3'd0, VAL_MIN, 1'b1, STATUS_OK};
    dir_tab[9]  = '{KIND_LOAD_B,  3'd1, 3'd1, VAL_MIN, 1'b1, STATUS_OK};
    dir_tab[10] = '{KIND_LOAD_B,  3'd0, 3'd1, VAL_MAX, 1'b1, STATUS_OK};
    dir_tab[11] = '{KIND_LOAD_B,  3'd1, 3'd0, -16'sd1, 1'b1, STATUS_OK};
    dir_tab[12] = '{KIND_LOAD_B,  3'd1, 3'd2, 16'sd3,  1'b1, STATUS_RANGE};
    dir_tab[13] = '{KIND_LOAD_B,  3'd7, 3'd0, 16'sd3,  1'b1, STATUS_RANGE};
    dir_tab[14] = '{KIND_IGNORED, 3'd7, 3'd7, -16'sd1, 1'b0, STATUS_OK};   // no result
    dir_tab[15] = '{KIND_COMPUTE, 3'd7, 3'd7, -16'sd1, 1'b0, STATUS_OK};   // extreme products

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every register reads back its reset value
    cfg_access(REG_ROWS_A, 1'b0, 4'd2);
    cfg_access(REG_INNER_SIZE, 1'b0, 4'd2);
    cfg_access(REG_COLS_B, 1'b0, 4'd2);

    foreach (dir_tab[i])
      send_item(dir_tab[i].kind, dir_tab[i].row, dir_tab[i].col, dir_tab[i].value,
                dir_tab[i].typed, dir_tab[i].status);
    settle();

    // random phases: a new shape each time, loads mostly inside it, then products
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: begin d0 = 4'd8;  d1 = 4'd8;  d2 = 4'd8;  end   // largest shape
        1: begin d0 = 4'd15; d1 = 4'd15; d2 = 4'd15; end   // saturates to 8
        2: begin d0 = 4'd1;  d1 = 4'd1;  d2 = 4'd1;  end
        3: begin d0 = 4'd0;  d1 = 4'd3;  d2 = 4'd4;  end   // no product rows
        4: begin d0 = 4'd3;  d1 = 4'd0;  d2 = 4'd5;  end   // empty inner sum
        5: begin d0 = 4'd2;  d1 = 4'd6;  d2 = 4'd0;  end   // no product columns
        6: begin d0 = 4'd12; d1 = 4'd0;  d2 = 4'd9;  end
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            d0 = 4'($urandom_range(0, 15));
            d1 = 4'($urandom_range(0, 15));
            d2 = 4'($urandom_range(0, 15));
          end else begin
            d0 = 4'($urandom_range(1, 4));
            d1 = 4'($urandom_range(1, 5));
            d2 = 4'($urandom_range(1, 4));
          end
        end
      endcase
      set_shape(d0, d1, d2);
      n_items = $urandom_range(8, 40);
      repeat (n_items) begin
        sel = $urandom_range(0, 99);
        if (sel < 72) begin
          // load inside the configured shape
          k = $urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A;
          lim_r = (k == KIND_LOAD_A) ? eff_dim(rows_cfg) : eff_dim(inner_cfg);
          lim_c = (k == KIND_LOAD_A) ? eff_dim(inner_cfg) : eff_dim(cols_cfg);
          r = (lim_r > 0) ? 3'($urandom_range(0, lim_r - 1)) : 3'($urandom_range(0, 7));
          c = (lim_c > 0) ? 3'($urandom_range(0, lim_c - 1)) : 3'($urandom_range(0, 7));
          send_item(k, r, c, pick_value(phase < 2), 1'b0, STATUS_OK);
        end else if (sel < 84) begin
          // load anywhere, often refused
          k = $urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A;
          send_item(k, 3'($urandom), 3'($urandom), pick_value(1'b0), 1'b0, STATUS_OK);
        end else if (sel < 89) begin
          send_item(KIND_IGNORED, 3'($urandom), 3'($urandom), 16'($urandom), 1'b0, STATUS_OK);
        end else if (sel < 97) begin
          send_item(KIND_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom), 1'b0, STATUS_OK);
        end else begin
          // hold off until every owed result is back
          settle();
        end
      end
      send_item(KIND_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom), 1'b0, STATUS_OK);
      settle();
      phase++;
    end

    settle();
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
